// ===== sv/frwc_pkg.sv =====
// Package for the freed-range write checker.
// Holds the request, result and token types and the fixed constants.
// No dependencies.
package frwc_pkg;

  localparam int AddrW    = 48;
  localparam int SizeW    = 48;
  localparam int WordW    = 64;
  localparam int HiW      = 50;
  localparam int OutCntW  = 7;
  localparam int CfgIdxW  = 1;

  // guard zone plus block header in front of the user pointer
  localparam logic [AddrW-1:0] BlockOffset = 48'd40;
  localparam logic [HiW-1:0]   BlockOffHi  = 50'd40;

  localparam logic [WordW-1:0] CanaryLowReset  = 64'h0f0f0f0f0f0f0f0f;
  localparam logic [WordW-1:0] CanaryHighReset = 64'hf0f0f0f0f0f0f0f0;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CANARY_LOW  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CANARY_HIGH = 1'b1;

  // request modes
  localparam logic MODE_FREE  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [AddrW-1:0]  address;
    logic [SizeW-1:0]  header_size;
    logic [WordW-1:0]  old_content;
  } frwc_req_t;

  typedef struct packed {
    logic               canary_hit;
    logic [OutCntW-1:0] freed_match_count;
    logic               table_full;
    logic [OutCntW-1:0] ranges_used;
  } frwc_result_t;

  // token travelling down the cell chain; lo holds the range base for a
  // free request and the target address for a write request
  typedef struct packed {
    logic               mode;
    logic [AddrW-1:0]   lo;
    logic [HiW-1:0]     hi;
    logic               canary_hit;
    logic               table_full;
    logic [OutCntW-1:0] ranges_used;
  } frwc_tok_t;

endpackage

// ===== sv/frwc_cell.sv =====
// One cell of the freed-range chain: stores one range and checks passing writes.
// Depends on frwc_pkg.
module frwc_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  frwc_pkg::frwc_tok_t tok_i,
  input  logic [CW-1:0]       tag_i,
  input  logic [CW-1:0]       cnt_i,
  output logic                vld_o,
  output frwc_pkg::frwc_tok_t tok_o,
  output logic [CW-1:0]       tag_o,
  output logic [CW-1:0]       cnt_o
);
  import frwc_pkg::*;

  logic [AddrW-1:0] lo_r;
  logic [HiW-1:0]   hi_r;
  logic             vld_r;
  frwc_tok_t        tok_r;
  logic [CW-1:0]    tag_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic             store;
  logic             hit;

  // a free request lands in the cell whose position equals its slot tag
  assign store = vld_i && (tok_i.mode == MODE_FREE) && (tag_i == CW'(IDX));

  // count this range if it was stored before the write request was issued and holds its address
  assign hit = vld_i && (tok_i.mode == MODE_WRITE) && (CW'(IDX) < tag_i) &&
               (tok_i.lo >= lo_r) && ({2'b00, tok_i.lo} <= hi_r);

  assign cnt_nxt = cnt_i + CW'(hit);

  // hold the stored range
  always_ff @(posedge clk) begin
    if (store) begin
      lo_r <= tok_i.lo;
      hi_r <= tok_i.hi;
    end
  end

  // advance the token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // advance the token payload
  always_ff @(posedge clk) begin
    tok_r <= tok_i;
    tag_r <= tag_i;
    cnt_r <= cnt_nxt;
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;
  assign tag_o = tag_r;
  assign cnt_o = cnt_r;

endmodule

// ===== sv/freed_range_write_checker.sv =====
// Top level of the freed-range write checker: entry stage, cell chain, config.
// Depends on frwc_pkg and frwc_cell.
//
//   channel   ports                          handshake
//   request   start, busy, in_req            accepted when start && !busy
//   result    out_valid, out_result          one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_wdata   written when cfg_we is high
//
// A request can be accepted every cycle while busy is low; its result appears
// at the output after the entry stage and the cell chain that every request
// walks, one cell per cycle, behind the requests issued before it.
// Reset clears the range count, the chain valids and restores the canaries;
// busy is registered: set while reset is held, cleared once it is released.
// Results are never held back.
module freed_range_write_checker #(
  parameter int FREE_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  frwc_pkg::frwc_req_t            in_req,
  output logic                           out_valid,
  output frwc_pkg::frwc_result_t         out_result,
  input  logic                           cfg_we,
  input  logic [frwc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [frwc_pkg::WordW-1:0]     cfg_wdata
);
  import frwc_pkg::*;

  localparam int CW = $clog2(FREE_ENTRIES + 1);

  logic             busy_r;
  logic [WordW-1:0] canary_lo_r;
  logic [WordW-1:0] canary_hi_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             accept;
  logic             full;
  logic [AddrW-1:0] base;
  logic [HiW-1:0]   range_hi;
  frwc_tok_t        tok_nxt;
  logic             ent_vld_r;
  frwc_tok_t        ent_tok_r;
  logic [CW-1:0]    ent_tag_r;

  logic          vld_c [0:FREE_ENTRIES];
  frwc_tok_t     tok_c [0:FREE_ENTRIES];
  logic [CW-1:0] tag_c [0:FREE_ENTRIES];
  logic [CW-1:0] cnt_c [0:FREE_ENTRIES];

  assign accept = start && !busy_r;
  assign full   = (count_r == CW'(FREE_ENTRIES));

  // hold busy through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  // write the canary patterns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canary_lo_r <= CanaryLowReset;
      canary_hi_r <= CanaryHighReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CANARY_LOW:  canary_lo_r <= cfg_wdata;
        CFG_CANARY_HIGH: canary_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // grow the range count on each stored free request
  always_comb begin
    count_nxt = count_r;
    if (accept && (in_req.mode == MODE_FREE) && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // form the range bounds and the per-request flags
  assign base     = in_req.address - BlockOffset;
  assign range_hi = {2'b00, base} + {2'b00, in_req.header_size} + BlockOffHi;

  always_comb begin
    tok_nxt.mode        = in_req.mode;
    tok_nxt.lo          = (in_req.mode == MODE_FREE) ? base : in_req.address;
    tok_nxt.hi          = range_hi;
    tok_nxt.canary_hit  = (in_req.mode == MODE_WRITE) &&
                          ((in_req.old_content == canary_lo_r) ||
                           (in_req.old_content == canary_hi_r));
    tok_nxt.table_full  = (in_req.mode == MODE_FREE) && full;
    tok_nxt.ranges_used = (32'(count_nxt) > 32'd127) ? 7'd127 : 7'(count_nxt);
  end

  // register the entry stage; a dropped free gets a slot tag no cell owns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else begin
      ent_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ent_tok_r <= tok_nxt;
    ent_tag_r <= count_r;
  end

  assign vld_c[0] = ent_vld_r;
  assign tok_c[0] = ent_tok_r;
  assign tag_c[0] = ent_tag_r;
  assign cnt_c[0] = '0;

  // chain of range cells
  for (genvar k = 0; k < FREE_ENTRIES; k++) begin : g_cell
    frwc_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_c[k]),
      .tok_i (tok_c[k]),
      .tag_i (tag_c[k]),
      .cnt_i (cnt_c[k]),
      .vld_o (vld_c[k+1]),
      .tok_o (tok_c[k+1]),
      .tag_o (tag_c[k+1]),
      .cnt_o (cnt_c[k+1])
    );
  end

  // drive the result from the last cell
  assign out_valid = vld_c[FREE_ENTRIES];

  always_comb begin
    out_result.canary_hit        = tok_c[FREE_ENTRIES].canary_hit;
    out_result.freed_match_count = (32'(cnt_c[FREE_ENTRIES]) > 32'd127) ?
                                   7'd127 : 7'(cnt_c[FREE_ENTRIES]);
    out_result.table_full        = tok_c[FREE_ENTRIES].table_full;
    out_result.ranges_used       = tok_c[FREE_ENTRIES].ranges_used;
  end

endmodule

// ===== sv/frwc_chk.sv =====
// Port-level checks for the freed-range write checker, bound to its top level.
// Depends on frwc_pkg and freed_range_write_checker.
module frwc_chk #(
  parameter int FREE_ENTRIES = 64
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   busy,
  input frwc_pkg::frwc_result_t out_result,
  input logic                   out_valid
);
  import frwc_pkg::*;

  localparam int UsedMax = (FREE_ENTRIES > 127) ? 127 : FREE_ENTRIES;

  // no result strobe right after reset
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // refuse requests right after a reset edge
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

  // stored range count never exceeds the table
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_result.ranges_used) <= UsedMax))
    else $error("ranges_used beyond table size");

  // a dropped free reports a full table and nothing else
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.table_full) |->
      ((32'(out_result.ranges_used) == UsedMax) && !out_result.canary_hit &&
       (out_result.freed_match_count == '0)))
    else $error("inconsistent table_full result");

  // a write never matches more ranges than are stored
  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.freed_match_count <= out_result.ranges_used))
    else $error("match count exceeds stored ranges");

endmodule

bind freed_range_write_checker frwc_chk #(
  .FREE_ENTRIES (FREE_ENTRIES)
) u_frwc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_result (out_result),
  .out_valid  (out_valid)
);
